[src/cdb_pkg.sv]
// ----------------------------------------------------------------------------
// cdb_pkg
// Types, sizes and command/status structs shared by the ring deque modules.
// ----------------------------------------------------------------------------
package cdb_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 5;
	localparam int COUNT_W = 5;
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INSERT     = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_READ       = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// logical index (from the front) that a memory access targets
	typedef enum logic [2:0] {
		IDX_FRONT,
		IDX_FRONT_NEW,
		IDX_BACK,
		IDX_LAST,
		IDX_POS,
		IDX_SHIFT,
		IDX_SHIFT_PREV
	} idx_sel_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_PUSHF,
		CNT_POPF,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic     take;
		logic     rd_en;
		idx_sel_t rd_sel;
		logic     wr_en;
		idx_sel_t wr_sel;
		logic     wr_from_rd;
		logic     idx_dec;
		cnt_op_t  cnt_op;
		logic     res_load;
		status_t  res_status;
		logic     res_rd;
	} cdb_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    pos_gt_cnt;
		logic    pos_ge_cnt;
		logic    shift_end;
		logic    out_free;
	} cdb_stat_t;

endpackage

[src/circular_deque_buffer_top.sv]
// A result is registered after its item passes the EXEC and DONE states;
// a new item is taken only in IDLE, or in DONE once the result is loaded.
// An insert at position p with n stored elements shifts n-p entries back,
// one read and then one write of the ring store per shifted entry.
// Reset (arst_n low) clears head, count, sequencer and result valid; the
// ring contents are not cleared.
// ----------------------------------------------------------------------------
// circular_deque_buffer_top
// Double-ended queue in a ring of DEPTH entries with positional insert/read.
// ----------------------------------------------------------------------------
module circular_deque_buffer_top import cdb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [DATA_W-1:0]  data,
	input  logic [POS_W-1:0]   position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DATA_W-1:0]  read_data,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] count
);

	cdb_cmd_t  cmd;
	cdb_stat_t stat;

	cdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.data      (data),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.status    (status),
		.count     (count)
	);

endmodule

[src/cdb_ctrl.sv]
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer for the ring deque: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module cdb_ctrl import cdb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cdb_stat_t stat,
	output cdb_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    rdf_q, rdf_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		st_d       = st_q;
		rdf_d      = rdf_q;
		in_ready   = 1'b0;
		cmd.rd_sel = IDX_FRONT;
		cmd.wr_sel = IDX_FRONT;
		cmd.cnt_op = CNT_HOLD;
		cmd.res_status = st_q;
		cmd.res_rd     = rdf_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = ST_OK;
				rdf_d   = 1'b0;
				state_d = S_DONE;
				case (stat.op)
					OP_PUSH_FRONT: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = IDX_FRONT_NEW;
							cmd.cnt_op = CNT_PUSHF;
						end
					end
					OP_PUSH_BACK: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = IDX_BACK;
							cmd.cnt_op = CNT_INC;
						end
					end
					OP_INSERT: begin
						if (stat.pos_gt_cnt) begin
							st_d = ST_BADPOS;
						end else if (stat.full) begin
							st_d = ST_FULL;
						end else if (stat.shift_end) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = IDX_POS;
							cmd.cnt_op = CNT_INC;
						end else begin
							// move one entry back, then come here again
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = IDX_SHIFT_PREV;
							state_d    = S_SHIFT_WR;
						end
					end
					OP_POP_FRONT: begin
						if (stat.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = IDX_FRONT;
							cmd.cnt_op = CNT_POPF;
							rdf_d      = 1'b1;
						end
					end
					OP_POP_BACK: begin
						if (stat.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = IDX_LAST;
							cmd.cnt_op = CNT_DEC;
							rdf_d      = 1'b1;
						end
					end
					OP_READ: begin
						if (stat.empty) begin
							st_d = ST_EMPTY;
						end else if (stat.pos_ge_cnt) begin
							st_d = ST_BADPOS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = IDX_POS;
							rdf_d      = 1'b1;
						end
					end
					default: begin
						st_d = ST_OK;
					end
				endcase
			end
			S_SHIFT_WR: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = IDX_SHIFT;
				cmd.wr_from_rd = 1'b1;
				cmd.idx_dec    = 1'b1;
				state_d        = S_EXEC;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.take = 1'b1;
						state_d  = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			rdf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rdf_q   <= rdf_d;
		end
	end

endmodule

[src/cdb_dp.sv]
// ----------------------------------------------------------------------------
// cdb_dp
// Ring store, head/count pointers, item latch and result register.
// ----------------------------------------------------------------------------
module cdb_dp import cdb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cdb_cmd_t           cmd,
	output cdb_stat_t          stat,
	input  logic [2:0]         opcode,
	input  logic [DATA_W-1:0]  data,
	input  logic [POS_W-1:0]   position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DATA_W-1:0]  read_data,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] count
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [POS_W-1:0]      pos_q;

	logic                  out_valid_q;
	logic [DATA_W-1:0]     read_data_q;
	status_t               status_q;
	logic [COUNT_W-1:0]    count_q;

	logic [CMP_W-1:0]      rd_lg, wr_lg;
	logic [PTR_W-1:0]      rd_slot, wr_slot;
	logic [DATA_WIDTH-1:0] wr_data;

	function automatic logic [CMP_W-1:0] logical_of(
		input idx_sel_t         s,
		input logic [CNT_W-1:0] c,
		input logic [POS_W-1:0] p,
		input logic [CNT_W-1:0] i
	);
		logic [CMP_W-1:0] r;
		case (s)
			IDX_FRONT:      r = '0;
			IDX_FRONT_NEW:  r = '1;  // wraps to head - 1
			IDX_BACK:       r = CMP_W'(c);
			IDX_LAST:       r = CMP_W'(c) - CMP_W'(1);
			IDX_POS:        r = CMP_W'(p);
			IDX_SHIFT:      r = CMP_W'(i);
			IDX_SHIFT_PREV: r = CMP_W'(i) - CMP_W'(1);
			default:        r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		rd_lg   = logical_of(cmd.rd_sel, cnt_q, pos_q, idx_q);
		wr_lg   = logical_of(cmd.wr_sel, cnt_q, pos_q, idx_q);
		rd_slot = head_q + rd_lg[PTR_W-1:0];
		wr_slot = head_q + wr_lg[PTR_W-1:0];
		wr_data = cmd.wr_from_rd ? rdata_q : data_q;
	end

	always_comb begin
		stat.op         = op_q;
		stat.full       = (cnt_q == CNT_W'(DEPTH));
		stat.empty      = (cnt_q == '0);
		stat.pos_gt_cnt = (CMP_W'(pos_q) > CMP_W'(cnt_q));
		stat.pos_ge_cnt = (CMP_W'(pos_q) >= CMP_W'(cnt_q));
		stat.shift_end  = (CMP_W'(idx_q) == CMP_W'(pos_q));
		stat.out_free   = !out_valid_q || out_ready;
	end

	// ring store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_slot] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= opcode_t'(opcode);
			data_q <= DATA_WIDTH'(data);
			pos_q  <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.take) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CNT_W'(1);
			end
			case (cmd.cnt_op)
				CNT_INC: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				CNT_PUSHF: begin
					head_q <= head_q - PTR_W'(1);
					cnt_q  <= cnt_q + CNT_W'(1);
				end
				CNT_POPF: begin
					head_q <= head_q + PTR_W'(1);
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				CNT_DEC: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			read_data_q <= cmd.res_rd ? DATA_W'(rdata_q) : '0;
			status_q    <= cmd.res_status;
			count_q     <= COUNT_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign count     = count_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_from_rd) |-> (CMP_W'(idx_q) > CMP_W'(pos_q)))
		else $error("shift write at or below insert position");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_DEC || cmd.cnt_op == CNT_POPF) |=>
		(cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("pop did not drop count by one");

endmodule
